FILE: design/bhcm_pkg.sv
// ----------------------------------------------------------------------------
// bhcm_pkg
// shared widths, codes and types of the banded heat-map color mapper
// ----------------------------------------------------------------------------
package bhcm_pkg;

	localparam int LEVEL_BITS = 16;
	// signed threshold width: doubled level plus tolerance, with sign
	localparam int TH_W = LEVEL_BITS + 4;
	// ramp numerator and denominator width
	localparam int DEN_W = LEVEL_BITS + 2;
	localparam int Q_W = 8;
	localparam int PROD_W = DEN_W + Q_W;
	localparam int CNT_W = $clog2(Q_W);

	localparam logic [Q_W-1:0] FULL = 8'd255;

	localparam logic [LEVEL_BITS-1:0] MIN_RESET = LEVEL_BITS'(0);
	localparam logic [LEVEL_BITS-1:0] MAX_RESET = LEVEL_BITS'(2560);
	localparam logic [LEVEL_BITS-1:0] TOL_RESET = LEVEL_BITS'(43);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOL = 2'd2;

	typedef enum logic [2:0] {
		BAND_HOLD  = 3'd0,
		BAND_BLUE  = 3'd1,
		BAND_BG    = 3'd2,
		BAND_GREEN = 3'd3,
		BAND_GR    = 3'd4,
		BAND_RED   = 3'd5,
		BAND_BLACK = 3'd6
	} band_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLASS,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic           done;
		logic [Q_W-1:0] quo;
		logic           inexact;
	} div_res_t;

endpackage

FILE: design/bhcm_ramp_div.sv
// ----------------------------------------------------------------------------
// bhcm_ramp_div
// radix-2 restoring divider giving floor(255*num/den), one quotient bit a cycle
// ----------------------------------------------------------------------------
module bhcm_ramp_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [bhcm_pkg::DEN_W-1:0]     num,
	input  logic [bhcm_pkg::DEN_W-1:0]     den,
	output bhcm_pkg::div_res_t             res
);

	logic                           busy_q;
	logic                           done_q;
	logic [bhcm_pkg::CNT_W-1:0]     cnt_q;
	logic [bhcm_pkg::PROD_W-1:0]    rem_q;
	logic [bhcm_pkg::PROD_W-1:0]    dsr_q;
	logic [bhcm_pkg::Q_W-1:0]       quo_q;
	logic                           ge;

	assign ge = (rem_q >= dsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == bhcm_pkg::CNT_W'(bhcm_pkg::Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// 255*num as (num << 8) - num
			rem_q <= {num, {bhcm_pkg::Q_W{1'b0}}} - {{bhcm_pkg::Q_W{1'b0}}, num};
			dsr_q <= {1'b0, den, {(bhcm_pkg::Q_W-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsr_q;
			end
			dsr_q <= {1'b0, dsr_q[bhcm_pkg::PROD_W-1:1]};
			quo_q <= {quo_q[bhcm_pkg::Q_W-2:0], ge};
		end
	end

	assign res.done    = done_q;
	assign res.quo     = quo_q;
	assign res.inexact = (rem_q != '0);

endmodule

FILE: design/banded_heatmap_color_mapper_unit.sv
// ----------------------------------------------------------------------------
// banded_heatmap_color_mapper_unit
// maps an unsigned Q8.8 level to a blue-green-red color through six bands
// ----------------------------------------------------------------------------
// steps: the level is registered, classified into a band, for ramps divided, then loaded to the output
// one item at a time: the input stalls until the result is loaded, which waits on output stalls;
//   the ramp divider takes one quotient bit per cycle for its 8-bit quotient, one item at a time
// a new input is taken while a finished result still waits on the output
// reset: registers return to min 0, max 2560, tolerance 43; held color is black
module banded_heatmap_color_mapper_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [bhcm_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [bhcm_pkg::LEVEL_BITS-1:0]      wr_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [bhcm_pkg::LEVEL_BITS-1:0]      level,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [7:0]                           red,
	output logic [7:0]                           green,
	output logic [7:0]                           blue,
	output logic [2:0]                           band
);

	bhcm_pkg::state_t                    state_q, state_nxt;
	logic [bhcm_pkg::LEVEL_BITS-1:0]     min_q, max_q, tol_q;
	logic [bhcm_pkg::LEVEL_BITS-1:0]     level_q;
	bhcm_pkg::band_t                     band_q, band_c, band_out_q;
	logic [bhcm_pkg::DEN_W-1:0]          num_q, den_q, num_c, den_c;
	logic [bhcm_pkg::Q_W-1:0]            quo_q;
	logic                                inexact_q;
	logic [7:0]                          last_red_q, last_green_q, last_blue_q;
	logic [7:0]                          red_c, green_c, blue_c;
	logic                                out_valid_q;
	logic                                div_go_q;
	logic                                out_load;
	logic                                in_xfer;
	logic [bhcm_pkg::Q_W-1:0]            fade;
	bhcm_pkg::div_res_t                  div_res;

	logic signed [bhcm_pkg::TH_W-1:0]    v, m, x, t, mn, mx, tl, s;
	logic signed [bhcm_pkg::TH_W-1:0]    a, b, c, d, e;
	logic signed [bhcm_pkg::TH_W-1:0]    num_full, den_full;

	localparam int ZP = bhcm_pkg::TH_W - bhcm_pkg::LEVEL_BITS;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= bhcm_pkg::MIN_RESET;
			max_q <= bhcm_pkg::MAX_RESET;
			tol_q <= bhcm_pkg::TOL_RESET;
		end else if (wr_en) begin
			case (wr_index)
				bhcm_pkg::CFG_MIN: min_q <= wr_data;
				bhcm_pkg::CFG_MAX: max_q <= wr_data;
				bhcm_pkg::CFG_TOL: tol_q <= wr_data;
				default: ;
			endcase
		end
	end

	// thresholds, in units of half a level step except the half-span
	always_comb begin
		v  = $signed({{(ZP-1){1'b0}}, level_q, 1'b0});
		m  = $signed({{(ZP-1){1'b0}}, min_q, 1'b0});
		x  = $signed({{(ZP-1){1'b0}}, max_q, 1'b0});
		t  = $signed({{(ZP-1){1'b0}}, tol_q, 1'b0});
		mn = $signed({{ZP{1'b0}}, min_q});
		mx = $signed({{ZP{1'b0}}, max_q});
		tl = $signed({{ZP{1'b0}}, tol_q});
		s  = mx - mn;
		a  = m + t;
		b  = s - tl;
		c  = s + tl;
		d  = x - t;
		e  = x;
		num_full = '0;
		den_full = '0;
		if (v > m && v <= a) begin
			band_c = bhcm_pkg::BAND_BLUE;
		end else if (v > a && v <= b) begin
			band_c   = bhcm_pkg::BAND_BG;
			num_full = v - a;
			den_full = b - a;
		end else if (v > b && v <= c) begin
			band_c = bhcm_pkg::BAND_GREEN;
		end else if (v > c && v <= d) begin
			band_c   = bhcm_pkg::BAND_GR;
			num_full = v - c;
			den_full = d - c;
		end else if (v > d && v <= e) begin
			band_c = bhcm_pkg::BAND_RED;
		end else if (v > e) begin
			band_c = bhcm_pkg::BAND_BLACK;
		end else begin
			band_c = bhcm_pkg::BAND_HOLD;
		end
		num_c = num_full[bhcm_pkg::DEN_W-1:0];
		den_c = den_full[bhcm_pkg::DEN_W-1:0];
	end

	bhcm_ramp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (num_q),
		.den    (den_q),
		.res    (div_res)
	);

	// fading channel: floor(255*(1-t)) = 255 - ceil(255*t)
	assign fade = bhcm_pkg::FULL - quo_q - bhcm_pkg::Q_W'(inexact_q);

	always_comb begin
		case (band_q)
			bhcm_pkg::BAND_BLUE: begin
				red_c = '0; green_c = '0; blue_c = bhcm_pkg::FULL;
			end
			bhcm_pkg::BAND_BG: begin
				red_c = '0; green_c = quo_q; blue_c = fade;
			end
			bhcm_pkg::BAND_GREEN: begin
				red_c = '0; green_c = bhcm_pkg::FULL; blue_c = '0;
			end
			bhcm_pkg::BAND_GR: begin
				red_c = quo_q; green_c = fade; blue_c = '0;
			end
			bhcm_pkg::BAND_RED: begin
				red_c = bhcm_pkg::FULL; green_c = '0; blue_c = '0;
			end
			bhcm_pkg::BAND_BLACK: begin
				red_c = '0; green_c = '0; blue_c = '0;
			end
			default: begin
				red_c = last_red_q; green_c = last_green_q; blue_c = last_blue_q;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bhcm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_stall  = 1'b1;
		out_load  = 1'b0;
		case (state_q)
			bhcm_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_nxt = bhcm_pkg::ST_CLASS;
				end
			end
			bhcm_pkg::ST_CLASS: begin
				if (band_c == bhcm_pkg::BAND_BG || band_c == bhcm_pkg::BAND_GR) begin
					state_nxt = bhcm_pkg::ST_DIV;
				end else begin
					state_nxt = bhcm_pkg::ST_FIN;
				end
			end
			bhcm_pkg::ST_DIV: begin
				if (div_res.done) begin
					state_nxt = bhcm_pkg::ST_FIN;
				end
			end
			bhcm_pkg::ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_load  = 1'b1;
					state_nxt = bhcm_pkg::ST_IDLE;
				end
			end
			default: state_nxt = bhcm_pkg::ST_IDLE;
		endcase
	end

	assign in_xfer = in_valid && !in_stall;

	// start the divider in the cycle after classification
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_go_q <= 1'b0;
		end else begin
			div_go_q <= (state_q == bhcm_pkg::ST_CLASS) && (state_nxt == bhcm_pkg::ST_DIV);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			level_q <= level;
		end
		if (state_q == bhcm_pkg::ST_CLASS) begin
			band_q <= band_c;
			num_q  <= num_c;
			den_q  <= den_c;
		end
		if (div_res.done) begin
			quo_q     <= div_res.quo;
			inexact_q <= div_res.inexact;
		end
		if (out_load) begin
			band_out_q <= band_q;
		end
	end

	// held color and output register share the same flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_red_q   <= '0;
			last_green_q <= '0;
			last_blue_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				last_red_q   <= red_c;
				last_green_q <= green_c;
				last_blue_q  <= blue_c;
				out_valid_q  <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign red       = last_red_q;
	assign green     = last_green_q;
	assign blue      = last_blue_q;
	assign band      = band_out_q;

endmodule

FILE: test/tb_banded_heatmap_color_mapper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_banded_heatmap_color_mapper_unit
// Drives Q8.8 levels through the color mapper under many band settings:
// reset values, normal ranges, crossed min/max, large tolerances and the
// extremes. A short list of directed levels comes first, some with the color
// typed in, then random levels aimed mostly at the band edges. Every result
// is checked field by field against its typed-in color or a behavioral band and
// ramp calculation, with random gaps on both channels, a long output hold and idle pauses.
// ----------------------------------------------------------------------------
module tb_banded_heatmap_color_mapper_unit;

	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 12;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 30;
	localparam int PHASES = 14;
	localparam int PHASE_ITEMS = 130;

	typedef struct packed {
		logic [7:0]      red;
		logic [7:0]      green;
		logic [7:0]      blue;
		bhcm_pkg::band_t bnd;
	} color_t;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_FIXED,
		ROW_BANDS
	} row_kind_t;

	typedef struct {
		row_kind_t                       kind;
		logic [bhcm_pkg::LEVEL_BITS-1:0] lvl;
		logic [bhcm_pkg::LEVEL_BITS-1:0] lo;
		logic [bhcm_pkg::LEVEL_BITS-1:0] hi;
		logic [bhcm_pkg::LEVEL_BITS-1:0] tol;
		color_t                          want;
	} stim_row_t;

	typedef struct {
		bit     fixed;
		color_t want;
	} offer_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            wr_en = 1'b0;
	logic [bhcm_pkg::CFG_IDX_W-1:0]  wr_index = bhcm_pkg::CFG_MIN;
	logic [bhcm_pkg::LEVEL_BITS-1:0] wr_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic [bhcm_pkg::LEVEL_BITS-1:0] level = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [7:0]                      red;
	logic [7:0]                      green;
	logic [7:0]                      blue;
	logic [2:0]                      band;

	// band registers and held color as the mapper should hold them
	logic [bhcm_pkg::LEVEL_BITS-1:0] cfg_min = bhcm_pkg::MIN_RESET;
	logic [bhcm_pkg::LEVEL_BITS-1:0] cfg_max = bhcm_pkg::MAX_RESET;
	logic [bhcm_pkg::LEVEL_BITS-1:0] cfg_tol = bhcm_pkg::TOL_RESET;
	logic [7:0]                      held_red = '0;
	logic [7:0]                      held_green = '0;
	logic [7:0]                      held_blue = '0;

	stim_row_t plan[$];
	offer_t    offered[$];
	color_t    colors_due[$];

	int unsigned gap_max = 16;
	int unsigned stall_max = 16;
	bit          long_hold_req = 1'b0;
	int unsigned mismatches = 0;
	int unsigned levels_in = 0;
	int unsigned colors_out = 0;
	int unsigned settings = 0;
	int unsigned band_hits[7];
	int unsigned quiet = 0;

	banded_heatmap_color_mapper_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.level     (level),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.band      (band)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	function automatic logic [7:0] ramp_share(input longint num, input longint den);
		if (den <= 0 || num <= 0)
			return 8'd0;
		if (num >= den)
			return bhcm_pkg::FULL;
		return 8'((num * longint'(bhcm_pkg::FULL)) / den);
	endfunction

	// thresholds in half-LSB units so the half-span stays exact
	function automatic color_t paint_level(input logic [bhcm_pkg::LEVEL_BITS-1:0] lv);
		longint v, m, x, t, s, a, b, c, d, e;
		color_t col;
		v = 2 * longint'(lv);
		m = 2 * longint'(cfg_min);
		x = 2 * longint'(cfg_max);
		t = 2 * longint'(cfg_tol);
		s = longint'(cfg_max) - longint'(cfg_min);
		a = m + t;
		b = s - longint'(cfg_tol);
		c = s + longint'(cfg_tol);
		d = x - t;
		e = x;
		col.bnd = bhcm_pkg::BAND_HOLD;
		if (v > m && v <= a) begin
			col.bnd = bhcm_pkg::BAND_BLUE;
			held_red = 8'd0;
			held_green = 8'd0;
			held_blue = bhcm_pkg::FULL;
		end else if (v > a && v <= b) begin
			col.bnd = bhcm_pkg::BAND_BG;
			held_red = 8'd0;
			held_green = ramp_share(v - a, b - a);
			held_blue = ramp_share(b - v, b - a);
		end else if (v > b && v <= c) begin
			col.bnd = bhcm_pkg::BAND_GREEN;
			held_red = 8'd0;
			held_green = bhcm_pkg::FULL;
			held_blue = 8'd0;
		end else if (v > c && v <= d) begin
			col.bnd = bhcm_pkg::BAND_GR;
			held_red = ramp_share(v - c, d - c);
			held_green = ramp_share(d - v, d - c);
			held_blue = 8'd0;
		end else if (v > d && v <= e) begin
			col.bnd = bhcm_pkg::BAND_RED;
			held_red = bhcm_pkg::FULL;
			held_green = 8'd0;
			held_blue = 8'd0;
		end else if (v > e) begin
			col.bnd = bhcm_pkg::BAND_BLACK;
			held_red = 8'd0;
			held_green = 8'd0;
			held_blue = 8'd0;
		end
		col.red = held_red;
		col.green = held_green;
		col.blue = held_blue;
		return col;
	endfunction

	task automatic report(input string what);
		mismatches++;
		$display("%0t ns mismatch: %s", $time, what);
	endtask

	task automatic add_level(input logic [bhcm_pkg::LEVEL_BITS-1:0] lv);
		stim_row_t row;
		row.kind = ROW_PREDICT;
		row.lvl = lv;
		plan.insert(plan.size(), row);
	endtask

	task automatic add_fixed(input logic [bhcm_pkg::LEVEL_BITS-1:0] lv, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b, input bhcm_pkg::band_t bnd);
		stim_row_t row;
		row.kind = ROW_FIXED;
		row.lvl = lv;
		row.want = '{red: r, green: g, blue: b, bnd: bnd};
		plan.insert(plan.size(), row);
	endtask

	task automatic add_bands(input logic [bhcm_pkg::LEVEL_BITS-1:0] lo,
			input logic [bhcm_pkg::LEVEL_BITS-1:0] hi,
			input logic [bhcm_pkg::LEVEL_BITS-1:0] tol);
		stim_row_t row;
		row.kind = ROW_BANDS;
		row.lo = lo;
		row.hi = hi;
		row.tol = tol;
		plan.insert(plan.size(), row);
	endtask

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic offer_level(input logic [bhcm_pkg::LEVEL_BITS-1:0] lv, input bit fixed,
			input color_t want);
		int unsigned gap;
		offer_t item;
		gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item.fixed = fixed;
		item.want = want;
		offered.insert(offered.size(), item);
		in_valid <= 1'b1;
		level <= lv;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (colors_due.size() != 0 || offered.size() != 0)
			@(negedge clk);
	endtask

	task automatic program_bands(input logic [bhcm_pkg::LEVEL_BITS-1:0] lo,
			input logic [bhcm_pkg::LEVEL_BITS-1:0] hi,
			input logic [bhcm_pkg::LEVEL_BITS-1:0] tol);
		logic [bhcm_pkg::CFG_IDX_W-1:0] idx[3];
		logic [bhcm_pkg::LEVEL_BITS-1:0] val[3];
		idx = '{bhcm_pkg::CFG_MIN, bhcm_pkg::CFG_MAX, bhcm_pkg::CFG_TOL};
		val = '{lo, hi, tol};
		for (int i = 0; i < 3; i++) begin
			wr_en <= 1'b1;
			wr_index <= idx[i];
			wr_data <= val[i];
			@(negedge clk);
		end
		wr_en <= 1'b0;
		settings++;
	endtask

	always @(posedge clk) begin : monitor
		offer_t item;
		color_t calc;
		color_t want;
		if (arst_n) begin
			if (wr_en) begin
				case (wr_index)
					bhcm_pkg::CFG_MIN: cfg_min = wr_data;
					bhcm_pkg::CFG_MAX: cfg_max = wr_data;
					bhcm_pkg::CFG_TOL: cfg_tol = wr_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				item = offered.pop_front();
				calc = paint_level(level);
				colors_due.insert(colors_due.size(), item.fixed ? item.want : calc);
				levels_in++;
			end
			if (out_valid && !out_stall) begin
				colors_out++;
				if (band < 7)
					band_hits[band]++;
				if (colors_due.size() == 0) begin
					report($sformatf("color %0d/%0d/%0d band %0d with no level pending",
						red, green, blue, band));
				end else begin
					want = colors_due.pop_front();
					if (red !== want.red)
						report($sformatf("result %0d red %0d, expected %0d",
							colors_out, red, want.red));
					if (green !== want.green)
						report($sformatf("result %0d green %0d, expected %0d",
							colors_out, green, want.green));
					if (blue !== want.blue)
						report($sformatf("result %0d blue %0d, expected %0d",
							colors_out, blue, want.blue));
					if (band !== want.bnd)
						report($sformatf("result %0d band %0d, expected %0d",
							colors_out, band, want.bnd));
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("no transfer for %0d cycles", quiet);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : receiver
		int unsigned hold;
		forever begin
			if (long_hold_req) begin
				hold = LONG_HOLD;
				long_hold_req = 1'b0;
			end else begin
				hold = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(out_valid && !out_stall));
			@(negedge clk);
		end
	end

	initial begin : stimulus
		stim_row_t row;
		color_t none;
		longint th[6];
		longint cand;
		logic [bhcm_pkg::LEVEL_BITS-1:0] lo, hi, tol, lv;
		int unsigned pick;

		none = '0;
		// reset bands: min 0, max 2560, tolerance 43
		add_fixed(16'd0, 8'd0, 8'd0, 8'd0, bhcm_pkg::BAND_HOLD);
		add_fixed(16'd1, 8'd0, 8'd0, 8'd255, bhcm_pkg::BAND_BLUE);
		add_fixed(16'd43, 8'd0, 8'd0, 8'd255, bhcm_pkg::BAND_BLUE);
		add_level(16'd44);
		add_level(16'd1258);
		add_fixed(16'd1259, 8'd0, 8'd255, 8'd0, bhcm_pkg::BAND_GREEN);
		add_fixed(16'd1301, 8'd0, 8'd255, 8'd0, bhcm_pkg::BAND_GREEN);
		add_level(16'd1302);
		add_level(16'd2517);
		add_fixed(16'd2518, 8'd255, 8'd0, 8'd0, bhcm_pkg::BAND_RED);
		add_fixed(16'd2560, 8'd255, 8'd0, 8'd0, bhcm_pkg::BAND_RED);
		add_fixed(16'd2561, 8'd0, 8'd0, 8'd0, bhcm_pkg::BAND_BLACK);
		add_fixed(16'hffff, 8'd0, 8'd0, 8'd0, bhcm_pkg::BAND_BLACK);
		add_fixed(16'd1, 8'd0, 8'd0, 8'd255, bhcm_pkg::BAND_BLUE);
		add_fixed(16'd0, 8'd0, 8'd0, 8'd255, bhcm_pkg::BAND_HOLD);
		// levels at or below min can still land in the green and green-red bands
		add_bands(16'd3000, 16'd4000, 16'd100);
		add_fixed(16'd500, 8'd0, 8'd255, 8'd0, bhcm_pkg::BAND_GREEN);
		add_level(16'd3000);
		add_level(16'd100);
		// min above max with full tolerance
		add_bands(16'hffff, 16'd0, 16'hffff);
		add_fixed(16'd0, 8'd0, 8'd255, 8'd0, bhcm_pkg::BAND_GREEN);
		add_fixed(16'd1, 8'd0, 8'd0, 8'd0, bhcm_pkg::BAND_BLACK);
		add_fixed(16'hffff, 8'd0, 8'd0, 8'd0, bhcm_pkg::BAND_BLACK);
		// widest range, no solid bands
		add_bands(16'd0, 16'hffff, 16'd0);
		add_level(16'd1);
		add_level(16'd32768);
		add_level(16'hffff);
		add_bands(16'd0, 16'd0, 16'd0);
		add_fixed(16'd1, 8'd0, 8'd0, 8'd0, bhcm_pkg::BAND_BLACK);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		while (plan.size() != 0) begin
			row = plan.pop_front();
			if (row.kind == ROW_BANDS) begin
				settle();
				program_bands(row.lo, row.hi, row.tol);
			end else begin
				offer_level(row.lvl, row.kind == ROW_FIXED, row.want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph % 6)
				0: begin
					lo = bhcm_pkg::MIN_RESET;
					hi = bhcm_pkg::MAX_RESET;
					tol = bhcm_pkg::TOL_RESET;
				end
				1: begin
					lo = 16'($urandom_range(0, 20000));
					hi = 16'(lo + $urandom_range(256, 40000));
					tol = 16'($urandom_range(0, 600));
				end
				2: begin
					lo = 16'($urandom_range(0, 65535));
					hi = 16'($urandom_range(0, 65535));
					tol = 16'($urandom_range(0, 65535));
				end
				3: begin
					hi = 16'($urandom_range(0, 30000));
					lo = 16'(hi + $urandom_range(1, 30000));
					tol = 16'($urandom_range(0, 2000));
				end
				4: begin
					lo = 16'($urandom_range(0, 4000));
					hi = 16'($urandom_range(4000, 65535));
					tol = 16'($urandom_range(10000, 65535));
				end
				default: begin
					lo = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
					hi = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
					tol = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
				end
			endcase
			program_bands(lo, hi, tol);
			gap_max = (ph % 4 < 2) ? 16 : 0;
			stall_max = (ph % 2 == 0) ? 16 : 0;
			th[0] = 2 * longint'(lo);
			th[1] = th[0] + 2 * longint'(tol);
			th[2] = longint'(hi) - longint'(lo) - longint'(tol);
			th[3] = longint'(hi) - longint'(lo) + longint'(tol);
			th[4] = 2 * longint'(hi) - 2 * longint'(tol);
			th[5] = 2 * longint'(hi);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 3 && n == 40)
					long_hold_req = 1'b1;
				pick = $urandom_range(0, 9);
				if (pick < 6) begin
					cand = (th[$urandom_range(0, 5)] + longint'($urandom_range(0, 8)) - 4) / 2;
					if (cand < 0)
						cand = 0;
					if (cand > 65535)
						cand = 65535;
					lv = 16'(cand);
				end else if (pick < 9) begin
					lv = 16'($urandom_range(0, 65535));
				end else begin
					case ($urandom_range(0, 3))
						0: lv = 16'h0000;
						1: lv = 16'hffff;
						2: lv = lo;
						default: lv = hi;
					endcase
				end
				offer_level(lv, 1'b0, none);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (colors_due.size() != 0)
			report($sformatf("%0d colors never came out", colors_due.size()));
		$display("%0d levels in, %0d colors out, over %0d band settings",
			levels_in, colors_out, settings);
		$display("colors per band, held to black: %0d %0d %0d %0d %0d %0d %0d",
			band_hits[0], band_hits[1], band_hits[2], band_hits[3],
			band_hits[4], band_hits[5], band_hits[6]);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/bhcm_pkg.sv
design/bhcm_ramp_div.sv
design/banded_heatmap_color_mapper_unit.sv
test/tb_banded_heatmap_color_mapper_unit.sv
